// ===== rtl/core/tcw_pkg.sv =====
// text console writer package: screen geometry, field widths, cell codes
// and the command and status bundles between controller and datapath
// no dependencies
package tcw_pkg;

   localparam int COLS  = 80;
   localparam int ROWS  = 25;
   localparam int CELLS = COLS * ROWS;

   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int ADDR_W = 11;
   localparam int CELL_W = 16;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;

   localparam logic [CHAR_W-1:0] NEWLINE_CODE    = 8'd10;
   localparam logic [CHAR_W-1:0] SPACE_CODE      = 8'h20;
   localparam logic [CHAR_W-1:0] NUL_CODE        = 8'h00;
   localparam logic [CELL_W-1:0] RESET_CELL      = 16'h0F20;
   localparam logic [ATTR_W-1:0] FILL_ATTR_RESET = 8'h0F;

   localparam logic REQ_READ = 1'b1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_FILL_ATTR = 1'b0;

   typedef struct packed {
      logic cap;
      logic init_wr;
      logic cnt_clear;
      logic cnt_load_col;
      logic clr_rd;
      logic chr_rd;
      logic chr_wr;
      logic cur_adv;
      logic next_line;
      logic blank_wr;
      logic top_adv;
      logic div_step;
      logic cell_rd;
      logic val_load;
      logic out_load;
   } tcw_cmd_type;

   typedef struct packed {
      logic init_last;
      logic cnt_last;
      logic col_last;
      logic row_last;
      logic rem_ge;
      logic idx_ok;
      logic is_read;
      logic is_newline;
      logic out_free;
   } tcw_status_type;

endpackage

// ===== rtl/core/tcw_ram.sv =====
// text console writer screen store: one write port, one registered read port
// depends on tcw_pkg
module tcw_ram (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [tcw_pkg::ADDR_W-1:0]   wr_addr,
   input  logic [tcw_pkg::CELL_W-1:0]   wr_data,
   input  logic                         rd_en,
   input  logic [tcw_pkg::ADDR_W-1:0]   rd_addr,
   output logic [tcw_pkg::CELL_W-1:0]   rd_data
);

   logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELLS];
   logic [tcw_pkg::CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/tcw_datapath.sv =====
// text console writer datapath: request capture, cursor, scroll offset,
// address unit, row divider, screen store and result register
// depends on tcw_pkg and tcw_ram
module tcw_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  tcw_pkg::tcw_cmd_type          cmd,
   output tcw_pkg::tcw_status_type       status,
   input  logic                          req_type,
   input  logic [tcw_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [tcw_pkg::ADDR_W-1:0]    req_cell_index,
   input  logic [tcw_pkg::ATTR_W-1:0]    fill_attr,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic [tcw_pkg::CELL_W-1:0]    rsp_cell_value,
   output logic [tcw_pkg::COL_W-1:0]     rsp_cursor_col,
   output logic [tcw_pkg::ROW_W-1:0]     rsp_cursor_row
);

   logic                         typ_ff, typ_in;
   logic [tcw_pkg::CHAR_W-1:0]   chr_ff, chr_in;
   logic [tcw_pkg::ADDR_W-1:0]   rem_ff, rem_in;
   logic [tcw_pkg::ROW_W-1:0]    drow_ff, drow_in;
   logic [tcw_pkg::ADDR_W-1:0]   cnt_ff, cnt_in;
   logic [tcw_pkg::COL_W-1:0]    col_ff, col_in;
   logic [tcw_pkg::ROW_W-1:0]    row_ff, row_in;
   logic [tcw_pkg::ROW_W-1:0]    top_ff, top_in;
   logic                         pend_ff, pend_in;
   logic [tcw_pkg::ADDR_W-1:0]   paddr_ff, paddr_in;
   logic [tcw_pkg::CELL_W-1:0]   val_ff, val_in;
   logic                         out_valid_ff, out_valid_in;
   logic [tcw_pkg::CELL_W-1:0]   out_val_ff, out_val_in;
   logic [tcw_pkg::COL_W-1:0]    out_col_ff, out_col_in;
   logic [tcw_pkg::ROW_W-1:0]    out_row_ff, out_row_in;

   logic [tcw_pkg::ROW_W-1:0]    lrow;
   logic [tcw_pkg::ROW_W:0]      rsum;
   logic [tcw_pkg::ROW_W-1:0]    prow;
   logic [tcw_pkg::COL_W-1:0]    acol;
   logic [tcw_pkg::ADDR_W-1:0]   maddr;

   logic                         we;
   logic [tcw_pkg::ADDR_W-1:0]   waddr;
   logic [tcw_pkg::CELL_W-1:0]   wdata;
   logic                         re;
   logic [tcw_pkg::CELL_W-1:0]   rdata;

   // logical row to physical row through the scroll offset, then row * COLS + col
   always_comb begin
      lrow = cmd.cell_rd ? drow_ff : row_ff;
      rsum = {1'b0, lrow} + {1'b0, top_ff};
      if (cmd.blank_wr) begin
         prow = top_ff;
         acol = cnt_ff[tcw_pkg::COL_W-1:0];
      end else begin
         if (rsum >= (tcw_pkg::ROW_W+1)'(tcw_pkg::ROWS)) begin
            prow = tcw_pkg::ROW_W'(rsum - (tcw_pkg::ROW_W+1)'(tcw_pkg::ROWS));
         end else begin
            prow = rsum[tcw_pkg::ROW_W-1:0];
         end
         if (cmd.cell_rd) begin
            acol = rem_ff[tcw_pkg::COL_W-1:0];
         end else if (cmd.clr_rd) begin
            acol = cnt_ff[tcw_pkg::COL_W-1:0];
         end else begin
            acol = col_ff;
         end
      end
      maddr = tcw_pkg::ADDR_W'(tcw_pkg::ADDR_W'(prow) * tcw_pkg::ADDR_W'(tcw_pkg::COLS))
            + tcw_pkg::ADDR_W'(acol);
   end

   always_comb begin
      we = cmd.init_wr | cmd.blank_wr | cmd.chr_wr | pend_ff;
      if (cmd.init_wr) begin
         waddr = cnt_ff;
      end else if (pend_ff) begin
         waddr = paddr_ff;
      end else begin
         waddr = maddr;
      end
      if (cmd.init_wr) begin
         wdata = tcw_pkg::RESET_CELL;
      end else if (cmd.blank_wr) begin
         wdata = {fill_attr, tcw_pkg::SPACE_CODE};
      end else if (cmd.chr_wr) begin
         wdata = {rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W], chr_ff};
      end else begin
         wdata = {rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W], tcw_pkg::NUL_CODE};
      end
      re = cmd.chr_rd | cmd.clr_rd | cmd.cell_rd;
   end

   tcw_ram u_ram (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (waddr),
      .wr_data (wdata),
      .rd_en   (re),
      .rd_addr (maddr),
      .rd_data (rdata)
   );

   always_comb begin
      typ_in  = cmd.cap ? req_type : typ_ff;
      chr_in  = cmd.cap ? req_char_code : chr_ff;
      rem_in  = rem_ff;
      drow_in = drow_ff;
      if (cmd.cap) begin
         rem_in  = req_cell_index;
         drow_in = '0;
      end else if (cmd.div_step) begin
         rem_in  = rem_ff - tcw_pkg::ADDR_W'(tcw_pkg::COLS);
         drow_in = drow_ff + tcw_pkg::ROW_W'(1);
      end

      cnt_in = cnt_ff;
      if (cmd.cnt_clear) begin
         cnt_in = '0;
      end else if (cmd.cnt_load_col) begin
         cnt_in = tcw_pkg::ADDR_W'(col_ff);
      end else if (cmd.init_wr || cmd.clr_rd || cmd.blank_wr) begin
         cnt_in = cnt_ff + tcw_pkg::ADDR_W'(1);
      end

      col_in = col_ff;
      row_in = row_ff;
      if (cmd.next_line) begin
         col_in = '0;
         if (row_ff != tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) begin
            row_in = row_ff + tcw_pkg::ROW_W'(1);
         end
      end else if (cmd.cur_adv) begin
         col_in = col_ff + tcw_pkg::COL_W'(1);
      end

      top_in = top_ff;
      if (cmd.top_adv) begin
         if (top_ff == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) begin
            top_in = '0;
         end else begin
            top_in = top_ff + tcw_pkg::ROW_W'(1);
         end
      end

      pend_in  = cmd.clr_rd;
      paddr_in = maddr;

      val_in = val_ff;
      if (cmd.cap) begin
         val_in = '0;
      end else if (cmd.val_load) begin
         val_in = rdata;
      end

      out_val_in   = out_val_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      out_valid_in = out_valid_ff & rsp_stall;
      if (cmd.out_load) begin
         out_val_in   = val_ff;
         out_col_in   = col_ff;
         out_row_in   = row_ff;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         top_ff       <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         top_ff       <= top_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      typ_ff     <= typ_in;
      chr_ff     <= chr_in;
      rem_ff     <= rem_in;
      drow_ff    <= drow_in;
      paddr_ff   <= paddr_in;
      val_ff     <= val_in;
      out_val_ff <= out_val_in;
      out_col_ff <= out_col_in;
      out_row_ff <= out_row_in;
   end

   always_comb begin
      status.init_last  = (cnt_ff == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1));
      status.cnt_last   = (cnt_ff == tcw_pkg::ADDR_W'(tcw_pkg::COLS - 1));
      status.col_last   = (col_ff == tcw_pkg::COL_W'(tcw_pkg::COLS - 1));
      status.row_last   = (row_ff == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
      status.rem_ge     = (rem_ff >= tcw_pkg::ADDR_W'(tcw_pkg::COLS));
      status.idx_ok     = (rem_ff < tcw_pkg::ADDR_W'(tcw_pkg::CELLS));
      status.is_read    = (typ_ff == tcw_pkg::REQ_READ);
      status.is_newline = (chr_ff == tcw_pkg::NEWLINE_CODE);
      status.out_free   = ~out_valid_ff | ~rsp_stall;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_cell_value = out_val_ff;
   assign rsp_cursor_col = out_col_ff;
   assign rsp_cursor_row = out_row_ff;

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff < tcw_pkg::COL_W'(tcw_pkg::COLS))
      else $error("cursor column out of range");

   a_top_range: assert property (@(posedge clock) disable iff (reset)
      top_ff < tcw_pkg::ROW_W'(tcw_pkg::ROWS))
      else $error("scroll offset out of range");

   a_waddr_range: assert property (@(posedge clock) disable iff (reset)
      we |-> (waddr < tcw_pkg::ADDR_W'(tcw_pkg::CELLS)))
      else $error("screen write beyond store");

   a_clear_write: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_rd |=> (we && waddr == $past(maddr)))
      else $error("line clear read not followed by its write");

endmodule

// ===== rtl/core/tcw_ctrl.sv =====
// text console writer controller: sequences store clearing, character
// writes, line clears, scrolls and cell reads; drives the datapath commands
// depends on tcw_pkg
module tcw_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  tcw_pkg::tcw_status_type    status,
   output tcw_pkg::tcw_cmd_type       cmd
);

   localparam logic [3:0] ST_INIT    = 4'd0;
   localparam logic [3:0] ST_IDLE    = 4'd1;
   localparam logic [3:0] ST_DECODE  = 4'd2;
   localparam logic [3:0] ST_DIV     = 4'd3;
   localparam logic [3:0] ST_RD_DATA = 4'd4;
   localparam logic [3:0] ST_WR_WR   = 4'd5;
   localparam logic [3:0] ST_CLR     = 4'd6;
   localparam logic [3:0] ST_CLR_END = 4'd7;
   localparam logic [3:0] ST_NEXT    = 4'd8;
   localparam logic [3:0] ST_SCROLL  = 4'd9;
   localparam logic [3:0] ST_DONE    = 4'd10;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_INIT: begin
            cmd.init_wr = 1'b1;
            if (status.init_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.cap  = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.is_read) begin
               state_in = status.idx_ok ? ST_DIV : ST_DONE;
            end else if (status.is_newline) begin
               cmd.cnt_load_col = 1'b1;
               state_in         = ST_CLR;
            end else begin
               cmd.chr_rd = 1'b1;
               state_in   = ST_WR_WR;
            end
         end
         ST_DIV: begin
            if (status.rem_ge) begin
               cmd.div_step = 1'b1;
            end else begin
               cmd.cell_rd = 1'b1;
               state_in    = ST_RD_DATA;
            end
         end
         ST_RD_DATA: begin
            cmd.val_load = 1'b1;
            state_in     = ST_DONE;
         end
         ST_WR_WR: begin
            cmd.chr_wr = 1'b1;
            if (status.col_last) begin
               state_in = ST_NEXT;
            end else begin
               cmd.cur_adv = 1'b1;
               state_in    = ST_DONE;
            end
         end
         ST_CLR: begin
            cmd.clr_rd = 1'b1;
            if (status.cnt_last) begin
               state_in = ST_CLR_END;
            end
         end
         ST_CLR_END: begin
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            cmd.next_line = 1'b1;
            if (status.row_last) begin
               cmd.cnt_clear = 1'b1;
               state_in      = ST_SCROLL;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCROLL: begin
            cmd.blank_wr = 1'b1;
            if (status.cnt_last) begin
               cmd.top_adv = 1'b1;
               state_in    = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   a_one_per_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second item taken before the first finished");

   a_load_after_work: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !$past(cmd.cap))
      else $error("result loaded in the cycle after capture");

   a_scroll_start: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == ST_SCROLL) |-> $past(status.row_last))
      else $error("scroll entered away from the bottom row");

endmodule

// ===== rtl/core/text_console_writer.sv =====
// text console writer top level: configuration registers, controller and datapath
// depends on tcw_pkg, tcw_ctrl, tcw_datapath
//
// channel   direction  handshake                   payload
// req       in         req_valid / req_stall       req_type, req_char_code, req_cell_index
// rsp       out        rsp_valid / rsp_stall       rsp_cell_value, rsp_cursor_col, rsp_cursor_row
// csr       in         psel, penable, pwrite       paddr, pwdata, prdata, pready
//
// after reset all cells of the store are swept to blank, one cell a cycle, with req_stall high
// character write: capture, cell read, write; at the line end a line step, and a blank row on a scroll
// newline: clears the line from the cursor column on, moves down, and scrolls from the bottom row
// read: the index divider takes one row a cycle, then the cell is read into the result
// one item at a time; the result register lets the next item be taken while a result waits
module text_console_writer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_type,
   input  logic [tcw_pkg::CHAR_W-1:0]         req_char_code,
   input  logic [tcw_pkg::ADDR_W-1:0]         req_cell_index,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [tcw_pkg::CELL_W-1:0]         rsp_cell_value,
   output logic [tcw_pkg::COL_W-1:0]          rsp_cursor_col,
   output logic [tcw_pkg::ROW_W-1:0]          rsp_cursor_row,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [tcw_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [tcw_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);

   logic [tcw_pkg::ATTR_W-1:0] fill_attr_ff, fill_attr_in;
   logic                       csr_wr;
   logic                       csr_hit;

   tcw_pkg::tcw_cmd_type       cmd;
   tcw_pkg::tcw_status_type    status;

   assign pready  = 1'b1;
   assign csr_hit = (paddr[2] == tcw_pkg::CSR_IDX_FILL_ATTR);
   assign csr_wr  = psel & penable & pwrite & pready & csr_hit;

   always_comb begin
      fill_attr_in = csr_wr ? pwdata[tcw_pkg::ATTR_W-1:0] : fill_attr_ff;
      prdata       = csr_hit ? tcw_pkg::CSR_DATA_W'(fill_attr_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_attr_ff <= tcw_pkg::FILL_ATTR_RESET;
      end else begin
         fill_attr_ff <= fill_attr_in;
      end
   end

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tcw_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_type       (req_type),
      .req_char_code  (req_char_code),
      .req_cell_index (req_cell_index),
      .fill_attr      (fill_attr_ff),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_cell_value (rsp_cell_value),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row)
   );

endmodule
